FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled during reset.
`define MMVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that an expression never holds.
`define MMVR_NEVER(label, expr, msg) \
  `MMVR_ASSERT(label, !(expr), msg)

`endif

FILE: src/mmvr_pkg.sv
`timescale 1ns / 1ps

package mmvr_pkg;

  localparam int SLOTS      = 8;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int MOTOR_W    = 4;
  localparam int POWER_W    = 8;
  localparam int STEP_W     = 9;
  localparam int FACTOR_W   = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 9'd256;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 9'd26;

  typedef logic [MOTOR_W-1:0]        motor_t;
  typedef logic signed [POWER_W-1:0] power_t;
  typedef logic signed [STEP_W-1:0]  step_t;
  typedef logic [FACTOR_W-1:0]       factor_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  typedef struct packed {
    power_t target;
    step_t  step;
    power_t power;
  } slot_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET,
    ST_TICK
  } state_t;

  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic REG_RAMP_ENABLE = 1'b0;
  localparam logic REG_STEP_FACTOR = 1'b1;

endpackage

FILE: src/mmvr_in_if.sv
`timescale 1ns / 1ps

interface mmvr_in_if;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  mmvr_pkg::motor_t      motor_id;
  mmvr_pkg::power_t      target_power;

  modport source (output valid, req_type, motor_id, target_power, input ready);
  modport sink   (input valid, req_type, motor_id, target_power, output ready);
endinterface

FILE: src/mmvr_out_if.sv
`timescale 1ns / 1ps

interface mmvr_out_if;
  logic                  valid;
  logic                  ready;
  mmvr_pkg::motor_t      out_motor;
  mmvr_pkg::power_t      power;
  logic                  accepted;
  logic                  last;

  modport source (output valid, out_motor, power, accepted, last, input ready);
  modport sink   (input valid, out_motor, power, accepted, last, output ready);
endinterface

FILE: src/mmvr_mem.sv
`timescale 1ns / 1ps

module mmvr_mem (
  input  logic                 clk,
  input  logic                 we,
  input  mmvr_pkg::slot_t      waddr,
  input  mmvr_pkg::slot_word_t wdata,
  input  logic                 re,
  input  mmvr_pkg::slot_t      raddr,
  output mmvr_pkg::slot_word_t rdata
);

  mmvr_pkg::slot_word_t mem [mmvr_pkg::SLOTS];
  mmvr_pkg::slot_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/mmvr_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmvr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  mmvr_in_if.sink              in_ch,
  mmvr_out_if.source           out_ch,
  input  logic                 ramp_enable,
  input  mmvr_pkg::factor_t    step_factor
);

  // (target - power) * factor / 256, truncated toward zero
  function automatic mmvr_pkg::step_t calc_step(mmvr_pkg::power_t tgt,
                                                mmvr_pkg::power_t pwr,
                                                mmvr_pkg::factor_t fac);
    logic signed [9:0]  diff;
    logic signed [19:0] prod;
    logic signed [19:0] biased;
    diff   = {{2{tgt[7]}}, tgt} - {{2{pwr[7]}}, pwr};
    prod   = diff * $signed({1'b0, fac});
    biased = prod[19] ? prod + 20'sd255 : prod;
    return biased[16:8];
  endfunction

  function automatic mmvr_pkg::power_t tick_power(mmvr_pkg::power_t tgt,
                                                  mmvr_pkg::step_t stp,
                                                  mmvr_pkg::power_t pwr,
                                                  logic en);
    logic signed [9:0] d;
    logic signed [9:0] s;
    logic signed [9:0] abs_d;
    logic signed [9:0] abs_s;
    logic signed [9:0] sum;
    mmvr_pkg::power_t  res;
    d     = {{2{tgt[7]}}, tgt} - {{2{pwr[7]}}, pwr};
    s     = {stp[8], stp};
    abs_d = d[9] ? -d : d;
    abs_s = s[9] ? -s : s;
    sum   = {{2{pwr[7]}}, pwr} + s;
    if (!en || stp == '0 || abs_d < abs_s) begin
      res = tgt;
    end else if (sum > 10'sd127) begin
      res = 8'sd127;
    end else if (sum < -10'sd128) begin
      res = -8'sd128;
    end else begin
      res = sum[7:0];
    end
    return res;
  endfunction

  mmvr_pkg::state_t     state_r, state_nxt;
  mmvr_pkg::cnt_t       used_r;
  mmvr_pkg::motor_t     motor_r [mmvr_pkg::SLOTS];
  mmvr_pkg::motor_t     req_motor_r;
  mmvr_pkg::power_t     req_target_r;
  mmvr_pkg::slot_t      slot_r, slot_nxt;
  logic                 hit_r, hit_nxt;
  logic                 full_r, full_nxt;

  logic                 out_valid_r;
  mmvr_pkg::motor_t     out_motor_r;
  mmvr_pkg::power_t     out_power_r;
  logic                 out_acc_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 hit;
  mmvr_pkg::slot_t      hit_idx;
  logic                 full;
  logic                 tick_last;
  mmvr_pkg::factor_t    factor_sat;
  mmvr_pkg::power_t     cur_power;
  mmvr_pkg::power_t     new_power;

  logic                 mem_we;
  mmvr_pkg::slot_t      mem_waddr;
  mmvr_pkg::slot_word_t mem_wdata;
  logic                 mem_re;
  mmvr_pkg::slot_t      mem_raddr;
  mmvr_pkg::slot_word_t mem_rdata;

  logic                 emit;
  mmvr_pkg::motor_t     emit_motor;
  mmvr_pkg::power_t     emit_power;
  logic                 emit_acc;
  logic                 emit_last;
  logic                 alloc;

  mmvr_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ch.ready = (state_r == mmvr_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign full        = (used_r == mmvr_pkg::CNT_W'(mmvr_pkg::SLOTS));
  assign factor_sat  = (step_factor > mmvr_pkg::FACTOR_ONE) ? mmvr_pkg::FACTOR_ONE
                                                             : step_factor;
  assign tick_last   = (mmvr_pkg::cnt_t'(slot_r) + 1'b1 == used_r);
  assign alloc       = !hit_r && !full_r;
  assign cur_power   = hit_r ? mem_rdata.power : '0;
  assign new_power   = tick_power(mem_rdata.target, mem_rdata.step, mem_rdata.power,
                                  ramp_enable);

  // slot lookup, lowest matching slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = mmvr_pkg::SLOTS - 1; i >= 0; i--) begin
      if (mmvr_pkg::CNT_W'(i) < used_r && motor_r[i] == in_ch.motor_id) begin
        hit     = 1'b1;
        hit_idx = mmvr_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mmvr_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == mmvr_pkg::REQ_SET) begin
            state_nxt = mmvr_pkg::ST_SET;
          end else if (used_r != '0) begin
            state_nxt = mmvr_pkg::ST_TICK;
          end
        end
      end
      mmvr_pkg::ST_SET: begin
        if (out_free) begin
          state_nxt = mmvr_pkg::ST_IDLE;
        end
      end
      mmvr_pkg::ST_TICK: begin
        if (out_free && tick_last) begin
          state_nxt = mmvr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mmvr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    slot_nxt   = slot_r;
    hit_nxt    = hit_r;
    full_nxt   = full_r;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = slot_r;
    mem_wdata  = mem_rdata;
    emit       = 1'b0;
    emit_motor = req_motor_r;
    emit_power = '0;
    emit_acc   = 1'b1;
    emit_last  = 1'b1;
    unique case (state_r)
      mmvr_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == mmvr_pkg::REQ_SET) begin
            slot_nxt  = hit ? hit_idx : used_r[mmvr_pkg::SLOT_W-1:0];
            hit_nxt   = hit;
            full_nxt  = !hit && full;
            mem_re    = 1'b1;
            mem_raddr = slot_nxt;
          end else begin
            slot_nxt  = '0;
            mem_re    = (used_r != '0);
            mem_raddr = '0;
          end
        end
      end
      mmvr_pkg::ST_SET: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_motor       = req_motor_r;
          emit_power       = full_r ? '0 : cur_power;
          emit_acc         = !full_r;
          emit_last        = 1'b1;
          mem_we           = !full_r;
          mem_wdata.target = req_target_r;
          mem_wdata.step   = calc_step(req_target_r, cur_power, factor_sat);
          mem_wdata.power  = cur_power;
        end
      end
      mmvr_pkg::ST_TICK: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_motor      = motor_r[slot_r];
          emit_power      = new_power;
          emit_acc        = 1'b1;
          emit_last       = tick_last;
          mem_we          = 1'b1;
          mem_wdata.power = new_power;
          if (!tick_last) begin
            slot_nxt  = slot_r + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = slot_nxt;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmvr_pkg::ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == mmvr_pkg::ST_SET && out_free && alloc) begin
        used_r <= used_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    hit_r  <= hit_nxt;
    full_r <= full_nxt;
    if (in_acc) begin
      req_motor_r  <= in_ch.motor_id;
      req_target_r <= in_ch.target_power;
    end
    if (state_r == mmvr_pkg::ST_SET && out_free && alloc) begin
      motor_r[slot_r] <= req_motor_r;
    end
    if (emit) begin
      out_motor_r <= emit_motor;
      out_power_r <= emit_power;
      out_acc_r   <= emit_acc;
      out_last_r  <= emit_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_motor = out_motor_r;
  assign out_ch.power     = out_power_r;
  assign out_ch.accepted  = out_acc_r;
  assign out_ch.last      = out_last_r;

  `MMVR_ASSERT(a_used_bound, used_r <= mmvr_pkg::CNT_W'(mmvr_pkg::SLOTS),
               "slot count beyond table size")
  `MMVR_ASSERT(a_used_grows, used_r >= $past(used_r), "slot count decreased")
  `MMVR_NEVER(a_rw_clash, mem_we && mem_re && mem_waddr == mem_raddr,
              "read and write of the same slot in one cycle")
  `MMVR_ASSERT(a_reject_last, out_valid_r && !out_acc_r |-> out_last_r,
               "rejected item not marked last")

endmodule

FILE: src/multi_motor_velocity_ramp_unit.sv
`timescale 1ns / 1ps

// Velocity ramp for up to SLOTS motors, slots taken in order of first use.
// in_ch: req_type 0 sets a target for motor_id (one result: current power,
//   accepted = 0 for a new motor when the table is full); req_type 1 is a
//   tick that gives one result per used slot, in slot order, last set on the
//   final one. A tick with no used slots gives no result.
// out_ch: valid/ready, one output register between the sequencer and the
//   receiver.
// APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready): 0x0 ramp
//   enable, 0x4 step factor in Q1.8. Write only while idle.
// Sequencing: a set-target does one slot RAM read, then computes and writes
//   back. A tick reads, modifies and writes back the used slots in turn, one
//   slot per cycle while the output register is free. The next item is taken
//   once the previous item's last result sits in the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the slot count and the output valid; no clearing pass.

module multi_motor_velocity_ramp_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  mmvr_in_if.sink                             in_ch,
  mmvr_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mmvr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mmvr_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mmvr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic              ramp_en_r;
  mmvr_pkg::factor_t factor_r;
  logic              cfg_wr;
  logic              reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_en_r <= 1'b1;
      factor_r  <= mmvr_pkg::FACTOR_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mmvr_pkg::REG_RAMP_ENABLE: ramp_en_r <= pwdata[0];
        mmvr_pkg::REG_STEP_FACTOR: factor_r  <= pwdata[mmvr_pkg::FACTOR_W-1:0];
        default:                   ramp_en_r <= ramp_en_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mmvr_pkg::REG_RAMP_ENABLE:
        prdata = {{(mmvr_pkg::CFG_DATA_W-1){1'b0}}, ramp_en_r};
      mmvr_pkg::REG_STEP_FACTOR:
        prdata = {{(mmvr_pkg::CFG_DATA_W-mmvr_pkg::FACTOR_W){1'b0}}, factor_r};
      default:
        prdata = '0;
    endcase
  end

  mmvr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .ramp_enable (ramp_en_r),
    .step_factor (factor_r)
  );

endmodule
